/* rtl/lru_pkg.sv */
// ----------------------------------------------------------------------------
// lru_pkg
// shared widths, reset constants and the per-lookup result word type
// ----------------------------------------------------------------------------
package lru_pkg;

    localparam int PAGE_W      = 16;
    localparam int FRAME_IDX_W = 4;
    localparam int CFG_W       = 5;
    localparam int FAULT_W     = 32;
    localparam int CFG_RESET   = 8;

    typedef struct packed {
        logic                   hit;
        logic [FRAME_IDX_W-1:0] frame_index;
        logic                   evicted_valid;
        logic [PAGE_W-1:0]      evicted_page;
    } lru_result_t;

endpackage

/* rtl/lru_frames.sv */
// ----------------------------------------------------------------------------
// lru_frames
// frame store with parallel lookup, lru victim pick and age-rank update
// ----------------------------------------------------------------------------
module lru_frames #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [$clog2(FRAMES+1)-1:0]   active_count,
    input  logic                          step,
    input  logic [lru_pkg::PAGE_W-1:0]    page,
    output lru_pkg::lru_result_t          res
);
    import lru_pkg::*;

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);
    localparam int SB    = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
    localparam logic [IDX_W-1:0] AGE_MAX = IDX_W'(FRAMES - 1);

    logic [SB-1:0]    frame_page_reg [FRAMES];
    logic [FRAMES-1:0] frame_valid_reg;
    logic [IDX_W-1:0] frame_age_reg  [FRAMES];
    logic [CNT_W-1:0] fill_ptr_reg;

    logic [SB-1:0]     key;
    logic [FRAMES-1:0] in_use;
    logic [FRAMES-1:0] match;
    logic [FRAMES-1:0] hit_oh;
    logic [FRAMES-1:0] fill_oh;
    logic [FRAMES-1:0] victim_oh;
    logic [FRAMES-1:0] sel;
    logic              hit;
    logic              fill;
    logic [IDX_W-1:0]  f_idx;
    logic [IDX_W-1:0]  ref_age;
    logic [SB-1:0]     ev_page;
    logic [IDX_W+FRAME_IDX_W-1:0] idx_wide;
    logic [SB+PAGE_W-1:0]         page_wide;

    assign key = page[SB-1:0];

    // lookup: per-frame compare, lowest matching frame wins
    always_comb
    begin
        logic lower;
        for (int i = 0; i < FRAMES; i++)
        begin
            in_use[i] = CNT_W'(i) < active_count;
            match[i]  = in_use[i] && frame_valid_reg[i] && (frame_page_reg[i] == key);
        end
        for (int i = 0; i < FRAMES; i++)
        begin
            lower = 1'b0;
            for (int j = 0; j < i; j++)
                lower = lower | match[j];
            hit_oh[i] = match[i] && !lower;
        end
    end

    assign hit  = |match;
    assign fill = !hit && (fill_ptr_reg < active_count);

    // victim: oldest frame in use, ties go to the lowest index
    always_comb
    begin
        logic beaten;
        for (int i = 0; i < FRAMES; i++)
        begin
            beaten = 1'b0;
            for (int j = 0; j < FRAMES; j++)
            begin
                if (in_use[j] && (j < i) && (frame_age_reg[j] >= frame_age_reg[i]))
                    beaten = 1'b1;
                if (in_use[j] && (j > i) && (frame_age_reg[j] > frame_age_reg[i]))
                    beaten = 1'b1;
            end
            victim_oh[i] = in_use[i] && !beaten;
            fill_oh[i]   = fill && (CNT_W'(i) == fill_ptr_reg);
        end
    end

    always_comb
    begin
        sel     = hit ? hit_oh : (fill ? fill_oh : victim_oh);
        f_idx   = '0;
        ref_age = '0;
        ev_page = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            if (sel[i])
            begin
                f_idx   = f_idx | IDX_W'(i);
                ref_age = ref_age | frame_age_reg[i];
            end
            if (victim_oh[i])
                ev_page = ev_page | frame_page_reg[i];
        end
        if (fill)
            ref_age = AGE_MAX;
    end

    assign idx_wide  = {{FRAME_IDX_W{1'b0}}, f_idx};
    assign page_wide = {{PAGE_W{1'b0}}, ev_page};

    always_comb
    begin
        res.hit           = hit;
        res.frame_index   = idx_wide[FRAME_IDX_W-1:0];
        res.evicted_valid = !hit && !fill;
        res.evicted_page  = (!hit && !fill) ? page_wide[PAGE_W-1:0] : '0;
    end

    // valid bits, age ranks and fill pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg <= '0;
            fill_ptr_reg    <= '0;
            for (int i = 0; i < FRAMES; i++)
                frame_age_reg[i] <= '0;
        end
        else if (step)
        begin
            if (fill)
                fill_ptr_reg <= fill_ptr_reg + CNT_W'(1);
            for (int i = 0; i < FRAMES; i++)
            begin
                if (sel[i])
                begin
                    frame_valid_reg[i] <= 1'b1;
                    frame_age_reg[i]   <= '0;
                end
                else if (in_use[i] && frame_valid_reg[i] &&
                         (frame_age_reg[i] < ref_age) && (frame_age_reg[i] < AGE_MAX))
                begin
                    frame_age_reg[i] <= frame_age_reg[i] + IDX_W'(1);
                end
            end
        end
    end

    // page tags, meaningful only while the frame is valid
    always_ff @(posedge clk)
    begin
        if (step && !hit)
        begin
            for (int i = 0; i < FRAMES; i++)
                if (sel[i])
                    frame_page_reg[i] <= key;
        end
    end

endmodule

/* rtl/lru_page_replacement.sv */
// ----------------------------------------------------------------------------
// lru_page_replacement
// fully associative page frame set with least recently used replacement
// ----------------------------------------------------------------------------
// an accepted word waits in the input register; its result is registered once the result slot is free
// throughput: one page reference per cycle while out_ready drains the result, set by the single lookup/update stage
// reset: all frames empty, ages and fill pointer zero, fault count zero,
//   frames_in_use back to 8 (or FRAMES if smaller); reset again after changing frames_in_use
// ----------------------------------------------------------------------------
module lru_page_replacement #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // reference input channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [lru_pkg::PAGE_W-1:0]         page,
    // result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               hit,
    output logic [lru_pkg::FRAME_IDX_W-1:0]    frame_index,
    output logic                               evicted_valid,
    output logic [lru_pkg::PAGE_W-1:0]         evicted_page,
    output logic [lru_pkg::FAULT_W-1:0]        fault_total,
    // frames_in_use write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lru_pkg::CFG_W-1:0]          cfg_data
);
    import lru_pkg::*;

    localparam int CNT_W = $clog2(FRAMES + 1);
    localparam int RESET_CNT = (FRAMES < CFG_RESET) ? FRAMES : CFG_RESET;

    // input register
    logic              in_valid_reg;
    logic              in_valid_next;
    logic [PAGE_W-1:0] page_reg;

    // result register
    logic              out_valid_reg;
    logic              out_valid_next;
    lru_result_t       res_reg;
    lru_result_t       res_next;

    // saturating fault counter, doubles as the result's running total
    logic [FAULT_W-1:0] fault_reg;
    logic [FAULT_W-1:0] fault_next;

    // active frame count, already held within 1..FRAMES
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    logic accept;
    logic advance;

    // the stage moves when the result slot is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    assign cfg_ready = 1'b1;

    lru_frames #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_frames (
        .clk          (clk),
        .rst_n        (rst_n),
        .active_count (count_reg),
        .step         (advance),
        .page         (page_reg),
        .res          (res_next)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;

        // a fault bumps the count unless it is already pinned at all ones
        fault_next = fault_reg;
        if (advance && !res_next.hit && (fault_reg != '1))
            fault_next = fault_reg + FAULT_W'(1);

        // clamp the written frame count to 1..FRAMES
        count_next = count_reg;
        if (cfg_valid)
        begin
            if (cfg_data == '0)
                count_next = CNT_W'(1);
            else if (int'(cfg_data) > FRAMES)
                count_next = CNT_W'(FRAMES);
            else
                count_next = CNT_W'(cfg_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fault_reg     <= '0;
            count_reg     <= CNT_W'(RESET_CNT);
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            fault_reg     <= fault_next;
            count_reg     <= count_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            page_reg <= page;
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid     = out_valid_reg;
    assign hit           = res_reg.hit;
    assign frame_index   = res_reg.frame_index;
    assign evicted_valid = res_reg.evicted_valid;
    assign evicted_page  = res_reg.evicted_page;
    assign fault_total   = fault_reg;

endmodule
